// ===== rtl/core/gnom_pkg.sv =====
package gnom_pkg;

    typedef enum logic [2:0] {
        OUT_UPDATED   = 3'd0,
        OUT_ADDED     = 3'd1,
        OUT_QUOTA     = 3'd2,
        OUT_FULL      = 3'd3,
        OUT_INVALID   = 3'd4,
        OUT_COUNT_SET = 3'd5
    } outcome_t;

    typedef enum logic {
        ACT_DETECT    = 1'b0,
        ACT_SET_COUNT = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic               action;
        logic [6:0]         cls_id;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] pos_z;
        logic [15:0]        size_x;
        logic [15:0]        size_y;
        logic [15:0]        size_z;
        logic               position_valid;
        logic [6:0]         quota_count;
    } in_item_t;

    typedef struct packed {
        outcome_t   outcome;
        logic [5:0] entry_index;
        logic [6:0] class_count;
        logic [6:0] occupancy;
    } out_item_t;

    typedef struct packed {
        logic [6:0]         cls_id;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] pos_z;
        logic [15:0]        size_x;
        logic [15:0]        size_y;
        logic [15:0]        size_z;
    } entry_t;

    // Control that travels alongside a distance through the pipeline
    typedef struct packed {
        logic valid;
        logic hit;
    } dist_tag_t;

    localparam int DIFF_W = 21;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int DIST_W = SQ_W + 2;

endpackage

// ===== rtl/core/gated_nearest_object_map.sv =====
// Gated nearest-object map.
// Input channel in_valid/in_ready/in_data carries one beat per request: a detection
// to associate or an expected count for a class. Output channel out_valid/out_ready/
// out_data returns exactly one beat per request. cfg_wr_en/cfg_wr_data write the
// distance gate in millimeters, taking effect for the next request.
// The table lives in a ring of MAX_OBJECTS cells that rotates once per request past
// a single distance pipeline; the next request is accepted only after the previous
// one has been scanned, drained and decided, so requests never overlap.
// After reset the per-class quota memory is cleared one entry per cycle, so in_ready
// stays low until every entry is cleared; the gate resets to 1000 mm, the table to empty.
// A finished result waits in the output register while the next request is accepted
// and scanned; if the receiver still stalls when that next result is ready, the
// block holds it until the earlier beat is taken.
module gated_nearest_object_map #(
    parameter int MAX_OBJECTS = 64,
    parameter int NUM_CLASSES = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gnom_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output gnom_pkg::out_item_t out_data,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data
);

    localparam int IW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CW = $clog2(MAX_OBJECTS + 1);
    localparam int AW = $clog2(NUM_CLASSES);
    localparam int DW = gnom_pkg::DIST_W;

    gnom_pkg::state_t    state_reg, state_next;
    gnom_pkg::in_item_t  req_reg;
    gnom_pkg::out_item_t out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic [15:0]         thr_reg;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0]       scan_cnt_reg, scan_cnt_next;
    logic [CW-1:0]       used_reg, used_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [DW-1:0]       best_reg, best_next;
    logic                found_reg, found_next;
    logic [IW-1:0]       best_idx_reg, best_idx_next;
    logic [IW-1:0]       idx1_reg, idx2_reg;
    logic [6:0]          quota_rd_reg;
    logic [6:0]          quota_mem [NUM_CLASSES];

    logic                accept, do_out, class_in_range;
    logic                q_we;
    logic [AW-1:0]       q_waddr;
    logic [6:0]          q_wdata, quota;
    logic                load_en;
    logic [IW-1:0]       load_idx;
    gnom_pkg::entry_t    load_data;
    gnom_pkg::entry_t    cell_q [MAX_OBJECTS];
    gnom_pkg::dist_tag_t tag_in, tag_out;
    logic [DW-1:0]       dist2;

    assign accept         = in_valid && in_ready;
    assign in_ready       = (state_reg == gnom_pkg::ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign out_data       = out_reg;
    assign class_in_range = (32'(req_reg.cls_id) < NUM_CLASSES);
    assign quota          = class_in_range ? quota_rd_reg : 7'd0;
    assign do_out         = (state_reg == gnom_pkg::ST_DECIDE) && (!out_valid_reg || out_ready);

    // Entry written on update or add
    assign load_data = '{cls_id: req_reg.cls_id, pos_x: req_reg.pos_x,
                         pos_y: req_reg.pos_y, pos_z: req_reg.pos_z,
                         size_x: req_reg.size_x, size_y: req_reg.size_y,
                         size_z: req_reg.size_z};

    // Ring of table cells
    for (genvar g = 0; g < MAX_OBJECTS; g++)
    begin : g_cell
        gnom_cell u_cell (
            .clk       (clk),
            .shift_en  (state_reg == gnom_pkg::ST_SCAN),
            .load_en   (load_en && (load_idx == IW'(g))),
            .load_data (load_data),
            .next_data (cell_q[(g + 1) % MAX_OBJECTS]),
            .data      (cell_q[g])
        );
    end

    // Distance pipeline fed by the head of the ring
    assign tag_in = '{valid: (state_reg == gnom_pkg::ST_SCAN),
                      hit:   (state_reg == gnom_pkg::ST_SCAN) && (scan_cnt_reg < used_reg)
                             && (cell_q[0].cls_id == req_reg.cls_id)};

    gnom_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag_in),
        .entry   (cell_q[0]),
        .det     (req_reg),
        .tag_out (tag_out),
        .dist2   (dist2)
    );

    // Quota memory write port: clearing pass or count write
    always_comb
    begin
        q_we    = 1'b0;
        q_waddr = clr_cnt_reg;
        q_wdata = 7'd0;
        if (state_reg == gnom_pkg::ST_CLEAR)
        begin
            q_we = 1'b1;
        end
        else if (accept && (in_data.action == gnom_pkg::ACT_SET_COUNT)
                 && (32'(in_data.cls_id) < NUM_CLASSES))
        begin
            q_we    = 1'b1;
            q_waddr = AW'(in_data.cls_id);
            q_wdata = in_data.quota_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            quota_mem[q_waddr] <= q_wdata;
        end
        if (accept)
        begin
            quota_rd_reg <= quota_mem[AW'(in_data.cls_id)];
        end
    end

    // Next state, scan bookkeeping and result
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        scan_cnt_next  = scan_cnt_reg;
        used_next      = used_reg;
        cnt_next       = cnt_reg;
        best_next      = best_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        load_en        = 1'b0;
        load_idx       = best_idx_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Keep the nearest hit; strict compare keeps the lowest index on ties
        if (tag_out.valid && tag_out.hit)
        begin
            cnt_next = cnt_reg + CW'(1);
            if (dist2 < best_reg)
            begin
                best_next     = dist2;
                best_idx_next = idx2_reg;
                found_next    = 1'b1;
            end
        end

        unique case (state_reg)
            gnom_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (32'(clr_cnt_reg) == NUM_CLASSES - 1)
                begin
                    state_next = gnom_pkg::ST_IDLE;
                end
            end
            gnom_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    scan_cnt_next = '0;
                    cnt_next      = '0;
                    found_next    = 1'b0;
                    best_next     = DW'(32'(thr_reg) * 32'(thr_reg));
                    state_next    = gnom_pkg::ST_SCAN;
                end
            end
            gnom_pkg::ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + CW'(1);
                if (32'(scan_cnt_reg) == MAX_OBJECTS - 1)
                begin
                    state_next = gnom_pkg::ST_DRAIN;
                end
            end
            gnom_pkg::ST_DRAIN:
            begin
                if (!tag_out.valid && !tag_in.valid)
                begin
                    state_next = gnom_pkg::ST_DECIDE;
                end
            end
            gnom_pkg::ST_DECIDE:
            begin
                if (do_out)
                begin
                    out_valid_next       = 1'b1;
                    out_next.entry_index = 6'd0;
                    out_next.class_count = 7'(cnt_reg);
                    out_next.occupancy   = 7'(used_reg);
                    if (req_reg.action == gnom_pkg::ACT_SET_COUNT)
                    begin
                        out_next.outcome = gnom_pkg::OUT_COUNT_SET;
                    end
                    else if (!req_reg.position_valid)
                    begin
                        out_next.outcome = gnom_pkg::OUT_INVALID;
                    end
                    else if (found_reg)
                    begin
                        out_next.outcome     = gnom_pkg::OUT_UPDATED;
                        out_next.entry_index = 6'(best_idx_reg);
                        load_en              = 1'b1;
                    end
                    else if (32'(cnt_reg) >= 32'(quota))
                    begin
                        out_next.outcome = gnom_pkg::OUT_QUOTA;
                    end
                    else if (32'(used_reg) >= MAX_OBJECTS)
                    begin
                        out_next.outcome = gnom_pkg::OUT_FULL;
                    end
                    else
                    begin
                        out_next.outcome     = gnom_pkg::OUT_ADDED;
                        out_next.entry_index = 6'(used_reg);
                        out_next.class_count = 7'(cnt_reg + CW'(1));
                        out_next.occupancy   = 7'(used_reg + CW'(1));
                        load_idx             = IW'(used_reg);
                        load_en              = 1'b1;
                        used_next            = used_reg + CW'(1);
                    end
                    state_next = gnom_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gnom_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gnom_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            scan_cnt_reg  <= '0;
            used_reg      <= '0;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            thr_reg       <= 16'd1000;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            scan_cnt_reg  <= scan_cnt_next;
            used_reg      <= used_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= in_data;
        end
        idx1_reg     <= IW'(scan_cnt_reg);
        idx2_reg     <= idx1_reg;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        out_reg      <= out_next;
    end

endmodule

// ===== rtl/core/gnom_cell.sv =====
module gnom_cell (
    input  logic              clk,
    input  logic              shift_en,
    input  logic              load_en,
    input  gnom_pkg::entry_t  load_data,
    input  gnom_pkg::entry_t  next_data,
    output gnom_pkg::entry_t  data
);

    gnom_pkg::entry_t data_reg;

    // Load a new entry, or take the neighbor's entry while the ring rotates
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            data_reg <= load_data;
        end
        else if (shift_en)
        begin
            data_reg <= next_data;
        end
    end

    assign data = data_reg;

endmodule

// ===== rtl/core/gnom_dist.sv =====
module gnom_dist (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gnom_pkg::dist_tag_t           tag_in,
    input  gnom_pkg::entry_t              entry,
    input  gnom_pkg::in_item_t            det,
    output gnom_pkg::dist_tag_t           tag_out,
    output logic [gnom_pkg::DIST_W-1:0]   dist2
);

    gnom_pkg::dist_tag_t tag1_reg, tag2_reg;
    logic signed [gnom_pkg::DIFF_W-1:0] dx, dy, dz;
    logic [gnom_pkg::DIFF_W-1:0] ax_reg, ay_reg, az_reg;
    logic [gnom_pkg::SQ_W-1:0] sx_reg, sy_reg, sz_reg;

    // Signed differences per axis
    assign dx = gnom_pkg::DIFF_W'(entry.pos_x) - gnom_pkg::DIFF_W'(det.pos_x);
    assign dy = gnom_pkg::DIFF_W'(entry.pos_y) - gnom_pkg::DIFF_W'(det.pos_y);
    assign dz = gnom_pkg::DIFF_W'(entry.pos_z) - gnom_pkg::DIFF_W'(det.pos_z);

    // Advance the tag through both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
        end
    end

    // Stage one: magnitudes; stage two: squares
    always_ff @(posedge clk)
    begin
        ax_reg <= dx[gnom_pkg::DIFF_W-1] ? -dx : dx;
        ay_reg <= dy[gnom_pkg::DIFF_W-1] ? -dy : dy;
        az_reg <= dz[gnom_pkg::DIFF_W-1] ? -dz : dz;
        sx_reg <= gnom_pkg::SQ_W'(ax_reg) * gnom_pkg::SQ_W'(ax_reg);
        sy_reg <= gnom_pkg::SQ_W'(ay_reg) * gnom_pkg::SQ_W'(ay_reg);
        sz_reg <= gnom_pkg::SQ_W'(az_reg) * gnom_pkg::SQ_W'(az_reg);
    end

    assign tag_out = tag2_reg;
    assign dist2   = gnom_pkg::DIST_W'(sx_reg) + gnom_pkg::DIST_W'(sy_reg)
                   + gnom_pkg::DIST_W'(sz_reg);

endmodule
